@@ src/ohi_pkg.sv @@
// Package for the open-addressing hash insert block.
// Holds sizes, operation and register codes, controller states and the
// remainder unit handshake types. Depends on nothing.
package ohi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int KEY_W       = 31;
  localparam int BIT_CNT_W   = $clog2(KEY_W);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);

  // Input operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration register indexes, taken from paddr[2].
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_PROBE_MODE = 1'b1;

  // Probe sequence codes.
  localparam logic PROBE_LINEAR    = 1'b0;
  localparam logic PROBE_QUADRATIC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_READ,
    ST_DONE
  } ohi_state_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } rem_rsp_t;

  // A size of zero counts as one; sizes above the table depth are clamped.
  function automatic logic [SIZE_W-1:0] size_in_use(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = size;
    if (n == '0) begin
      n = SIZE_W'(1);
    end else if (n > SIZE_MAX) begin
      n = SIZE_MAX;
    end
    return n;
  endfunction

endpackage

@@ src/ohi_if.sv @@
// Valid/ready channel interfaces for the hash insert block.
// Depends on ohi_pkg for the field widths.
interface ohi_in_if;
  import ohi_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;
  logic [IDX_W-1:0] slot_select;

  modport source (output valid, mode, key, slot_select, input ready);
  modport sink   (input valid, mode, key, slot_select, output ready);
endinterface

interface ohi_out_if;
  import ohi_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot_index;
  logic [KEY_W-1:0] slot_value;
  logic             table_full;

  modport source (output valid, slot_index, slot_value, table_full, input ready);
  modport sink   (input valid, slot_index, slot_value, table_full, output ready);
endinterface

@@ src/ohi_rem.sv @@
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
// Depends on ohi_pkg for widths and the request and response structs.
module ohi_rem (
  input  logic              clk,
  input  logic              rst,
  input  ohi_pkg::rem_req_t req,
  output ohi_pkg::rem_rsp_t rsp
);
  import ohi_pkg::*;

  logic                 busy;
  logic                 done;
  logic [BIT_CNT_W-1:0] cnt;
  logic [KEY_W-1:0]     dvd;
  logic [SIZE_W-1:0]    dvs;
  logic [IDX_W-1:0]     rem;
  logic [SIZE_W-1:0]    trial;
  logic [SIZE_W-1:0]    rem_next;

  // The partial remainder stays below the divisor, so the shifted value fits.
  assign trial    = {rem, dvd[KEY_W-1]};
  assign rem_next = (trial >= dvs) ? (trial - dvs) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= BIT_CNT_W'(KEY_W - 1);
    end else if (busy) begin
      dvd <= {dvd[KEY_W-2:0], 1'b0};
      rem <= rem_next[IDX_W-1:0];
      cnt <= cnt - BIT_CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

@@ src/open_addressing_hash_insert.sv @@
// Open-addressing hash insert, top level: slot memory, probe controller, APB registers.
// Depends on ohi_pkg, ohi_in_if, ohi_out_if and ohi_rem.
//
// The block holds a table of 64 key slots, all empty after reset (tracked by one valid
// bit per slot, so no clearing pass is needed). An insert word first reduces its key
// modulo the table size in use with a bit-serial remainder unit, then probes the slot
// memory with one read issued per cycle and the check of each read in the cycle after.
// The key goes into the first empty slot; if none is found, table_full is reported and
// nothing is stored. A read word returns the key held at a slot. One word is worked on
// at a time; the result register lets the next word be accepted while a result still
// waits on the output. Registers: table_size at 0x0, probe_mode at 0x4; write them only
// while the block is idle.
module open_addressing_hash_insert (
  input  logic                    clk,
  input  logic                    rst,
  ohi_in_if.sink                  in_ch,
  ohi_out_if.source               out_ch,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ohi_pkg::ADDR_W-1:0] paddr,
  input  logic [ohi_pkg::DATA_W-1:0] pwdata,
  output logic [ohi_pkg::DATA_W-1:0] prdata,
  output logic                    pready
);
  import ohi_pkg::*;

  // Configuration registers.
  logic [SIZE_W-1:0] table_size;
  logic              probe_mode;
  logic [SIZE_W-1:0] n;

  assign n      = size_in_use(table_size);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
      probe_mode <= PROBE_LINEAR;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TABLE_SIZE: table_size <= pwdata[SIZE_W-1:0];
        REG_PROBE_MODE: probe_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TABLE_SIZE: prdata = DATA_W'(table_size);
      REG_PROBE_MODE: prdata = DATA_W'(probe_mode);
      default:        prdata = '0;
    endcase
  end

  // Controller and probe datapath.
  ohi_state_t        state;
  ohi_state_t        state_next;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  sel_q;
  logic              sel_in_range;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  step;
  logic [SIZE_W-1:0] issued;
  logic [SIZE_W-1:0] checked;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  res_index;
  logic [KEY_W-1:0]  res_value;
  logic              res_full;
  logic              out_valid;

  logic              accept;
  logic              found;
  logic              exhausted;
  logic              issue;
  logic              out_load;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;
  logic [SIZE_W-1:0] pos_sum;
  logic [IDX_W-1:0]  pos_adv;
  logic [SIZE_W-1:0] step_sum;
  logic [IDX_W-1:0]  step_adv;

  // Slot memory with a valid bit per slot; an entry never written reads as empty.
  logic [KEY_W-1:0]       slot_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_vld;
  logic [IDX_W-1:0]       raddr;
  logic [KEY_W-1:0]       rd_data;
  logic                   rd_vld;
  logic                   mem_we;
  logic [KEY_W-1:0]       rd_eff;

  always_ff @(posedge clk) begin
    rd_data <= slot_mem[raddr];
    rd_vld  <= slot_vld[raddr];
    if (mem_we) begin
      slot_mem[rd_addr] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (mem_we) begin
      slot_vld[rd_addr] <= 1'b1;
    end
  end

  assign rd_eff = rd_vld ? rd_data : '0;

  assign accept    = in_ch.valid && in_ch.ready;
  assign found     = rd_pend && (rd_eff == '0);
  assign exhausted = rd_pend && !found && (checked == n - SIZE_W'(1));

  // Both operands stay below n, so one compare and subtract reduces the sum.
  assign pos_sum  = SIZE_W'(pos) + SIZE_W'(step);
  assign pos_adv  = (pos_sum >= n) ? IDX_W'(pos_sum - n) : IDX_W'(pos_sum);
  // Successive squares differ by odd numbers, so the quadratic step grows by two.
  assign step_sum = SIZE_W'(step) + SIZE_W'(2);
  assign step_adv = (step_sum >= n) ? IDX_W'(step_sum - n) : IDX_W'(step_sum);

  ohi_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_ch.mode == OP_READ) ? ST_READ : ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_rsp.done) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (found || exhausted) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = (state == ST_IDLE);
    rem_req.start    = (state == ST_IDLE) && accept && (in_ch.mode == OP_INSERT);
    rem_req.dividend = in_ch.key;
    rem_req.divisor  = n;
    mem_we           = (state == ST_PROBE) && found;
    issue            = (state == ST_PROBE) && !found && !exhausted && (issued < n);
    out_load         = (state == ST_DONE) && (!out_valid || out_ch.ready);
    raddr            = (state == ST_IDLE) ? in_ch.slot_select : pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_PROBE) begin
        rd_pend <= issue;
      end else begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          key_q        <= in_ch.key;
          sel_q        <= in_ch.slot_select;
          sel_in_range <= (SIZE_W'(in_ch.slot_select) < n);
        end
      end
      ST_MOD: begin
        if (rem_rsp.done) begin
          pos     <= rem_rsp.rem;
          step    <= (n == SIZE_W'(1)) ? '0 : IDX_W'(1);
          issued  <= '0;
          checked <= '0;
        end
      end
      ST_PROBE: begin
        if (rd_pend) begin
          checked <= checked + SIZE_W'(1);
        end
        if (found) begin
          res_index <= rd_addr;
          res_value <= key_q;
          res_full  <= 1'b0;
        end else if (exhausted) begin
          res_index <= '0;
          res_value <= '0;
          res_full  <= 1'b1;
        end
        if (issue) begin
          rd_addr <= pos;
          issued  <= issued + SIZE_W'(1);
          pos     <= pos_adv;
          if (probe_mode == PROBE_QUADRATIC) begin
            step <= step_adv;
          end
        end
      end
      ST_READ: begin
        res_index <= sel_q;
        res_value <= sel_in_range ? rd_eff : '0;
        res_full  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.slot_index <= res_index;
      out_ch.slot_value <= res_value;
      out_ch.table_full <= res_full;
    end
  end

  assign out_ch.valid = out_valid;

  // A slot is only written after a probe read found it empty.
  a_write_on_empty: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_PROBE) && rd_pend && (rd_eff == '0))
    else $error("slot written without an empty probe result");

  // No more slots are checked than the table size in use.
  a_checked_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (checked < n) && (issued <= n))
    else $error("probe count beyond table size");

  // Every issued probe address lies inside the table in use.
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (SIZE_W'(pos) < n))
    else $error("probe address outside table");

  // The remainder unit only finishes while the controller waits for it.
  a_rem_done_state: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> (state == ST_MOD))
    else $error("remainder finished outside its state");

  // A result waiting on the output is held until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_ch.slot_index)
      && $stable(out_ch.slot_value) && $stable(out_ch.table_full))
    else $error("pending result changed");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for open_addressing_hash_insert: directed and random insert
// and read words with idle gaps and output stalls, checked against a built-in model of
// the slot table. Depends on ohi_pkg, ohi_in_if and ohi_out_if from the RTL.
module testbench;
  import ohi_pkg::*;

  localparam int SLOTS       = 64;
  localparam int PHASES      = 11;
  localparam int PHASE_WORDS = 85;
  localparam int INSERT_PCT  = 45;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 150;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] slot_select;
  } hash_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic [KEY_W-1:0] slot_value;
    logic             table_full;
  } hash_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ohi_in_if  word_in ();
  ohi_out_if word_out ();

  open_addressing_hash_insert dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (word_in),
    .out_ch  (word_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the slot table and of the two registers.
  logic [KEY_W-1:0] key_table [SLOTS];
  logic [6:0]       cfg_size;
  logic             cfg_probe;

  hash_word_t   pending_words [$];
  hash_result_t expected_results [$];

  int  error_count  = 0;
  int  results_seen = 0;
  int  tx_gap;
  int  rx_wait;
  int  hold_left;
  bit  tx_idle_en;
  bit  rx_idle_en;

  int phase_size [PHASES] = '{1, 0, 16, 24, 32, 40, 48, 56, 64, 100, 127};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Zero selects one slot; anything above the table depth is clamped to it.
  function automatic int active_slots();
    int n;
    n = int'(cfg_size);
    if (n == 0) begin
      n = 1;
    end else if (n > SLOTS) begin
      n = SLOTS;
    end
    return n;
  endfunction

  function automatic hash_result_t predict_word(hash_word_t w);
    hash_result_t     r;
    longint unsigned  n;
    longint unsigned  i;
    longint unsigned  offset;
    longint unsigned  pos;
    bit               placed;
    r      = '0;
    n      = longint'(active_slots());
    placed = 1'b0;
    if (w.mode == OP_READ) begin
      r.slot_index = w.slot_select;
      if (longint'(w.slot_select) < n) begin
        r.slot_value = key_table[w.slot_select];
      end
      return r;
    end
    for (i = 0; i < n && !placed; i++) begin
      offset = (cfg_probe == PROBE_QUADRATIC) ? i * i : i;
      pos    = (longint'(w.key) + offset) % n;
      if (key_table[pos] == '0) begin
        // A zero key lands here too, so the slot still reads as empty.
        key_table[pos] = w.key;
        r.slot_index   = IDX_W'(pos);
        r.slot_value   = w.key;
        placed         = 1'b1;
      end
    end
    if (!placed) begin
      r.table_full = 1'b1;
    end
    return r;
  endfunction

  function automatic hash_word_t make_word(logic mode, logic [KEY_W-1:0] key,
                                           logic [IDX_W-1:0] sel);
    hash_word_t w;
    w.mode        = mode;
    w.key         = key;
    w.slot_select = sel;
    return w;
  endfunction

  function automatic hash_word_t random_word();
    hash_word_t w;
    w.mode = ($urandom_range(99) < INSERT_PCT) ? OP_INSERT : OP_READ;
    case ($urandom_range(9))
      0:       w.key = '0;
      1:       w.key = '1;
      2, 3, 4: w.key = KEY_W'($urandom_range(1, 300));
      default: w.key = KEY_W'($urandom);
    endcase
    if ($urandom_range(1) == 0) begin
      w.slot_select = IDX_W'($urandom_range(active_slots() - 1));
    end else begin
      w.slot_select = IDX_W'($urandom_range(SLOTS - 1));
    end
    return w;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, field, got, want);
    error_count++;
  endtask

  task automatic check_result();
    hash_result_t want;
    if (expected_results.size() == 0) begin
      $display("mismatch at result %0d: result arrived with nothing expected", results_seen);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    if (word_out.slot_index !== want.slot_index) begin
      report_mismatch("slot_index", word_out.slot_index, want.slot_index);
    end
    if (word_out.slot_value !== want.slot_value) begin
      report_mismatch("slot_value", word_out.slot_value, want.slot_value);
    end
    if (word_out.table_full !== want.table_full) begin
      report_mismatch("table_full", word_out.table_full, want.table_full);
    end
  endtask

  task automatic reg_write(logic reg_idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_TABLE_SIZE) begin
      cfg_size = value[6:0];
    end else begin
      cfg_probe = value[0];
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || word_in.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sender: offers the oldest pending word, predicts it once it is taken.
  always @(posedge clk) begin
    if (rst) begin
      word_in.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (word_in.valid && word_in.ready) begin
        expected_results.push_back(predict_word(pending_words.pop_front()));
        tx_gap = tx_idle_en ? $urandom_range(9) : 0;
      end
      if (tx_gap > 0 || pending_words.size() == 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end
        word_in.valid <= 1'b0;
      end else begin
        word_in.valid       <= 1'b1;
        word_in.mode        <= pending_words[0].mode;
        word_in.key         <= pending_words[0].key;
        word_in.slot_select <= pending_words[0].slot_select;
      end
    end
  end

  // Receiver: checks each result word and stalls at random, once for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      word_out.ready <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        check_result();
        results_seen++;
        rx_wait = rx_idle_en ? $urandom_range(9) : 0;
        if (results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        word_out.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    int p;
    int k;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    word_in.valid       = 1'b0;
    word_in.mode        = OP_INSERT;
    word_in.key         = '0;
    word_in.slot_select = '0;
    word_out.ready      = 1'b0;
    tx_idle_en          = 1'b1;
    rx_idle_en          = 1'b1;
    cfg_size            = 7'd10;
    cfg_probe           = PROBE_LINEAR;
    foreach (key_table[i]) key_table[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: reads of an empty table, in and out of
    // range, a zero key, the largest key, collisions, and inserts into a full table.
    pending_words.push_back(make_word(OP_READ, '0, 6'd0));
    pending_words.push_back(make_word(OP_READ, '1, 6'd9));
    pending_words.push_back(make_word(OP_READ, '0, 6'd10));
    pending_words.push_back(make_word(OP_READ, '1, 6'd63));
    pending_words.push_back(make_word(OP_INSERT, 31'd1, 6'd0));
    pending_words.push_back(make_word(OP_INSERT, 31'd0, 6'd63));
    pending_words.push_back(make_word(OP_INSERT, '1, 6'd0));
    pending_words.push_back(make_word(OP_INSERT, 31'd11, 6'd0));
    pending_words.push_back(make_word(OP_INSERT, 31'd21, 6'd0));
    pending_words.push_back(make_word(OP_READ, '0, 6'd1));
    pending_words.push_back(make_word(OP_READ, '0, 6'd7));
    for (k = 100; k <= 105; k++) begin
      pending_words.push_back(make_word(OP_INSERT, KEY_W'(k), 6'd0));
    end
    pending_words.push_back(make_word(OP_INSERT, 31'd106, 6'd0));
    pending_words.push_back(make_word(OP_INSERT, 31'd0, 6'd0));
    pending_words.push_back(make_word(OP_READ, '0, 6'd0));
    pending_words.push_back(make_word(OP_READ, '0, 6'd9));
    wait_idle();

    // The size mostly grows in steps, so most phases bring fresh empty slots to probe; 0, 100 and 127 test the clamps.
    for (p = 0; p < PHASES; p++) begin
      reg_write(REG_TABLE_SIZE, DATA_W'(phase_size[p]));
      reg_write(REG_PROBE_MODE, (p % 2 == 0) ? DATA_W'(PROBE_QUADRATIC)
                                             : DATA_W'(PROBE_LINEAR));
      tx_idle_en = ($urandom_range(2) != 0);
      rx_idle_en = ($urandom_range(2) != 0);
      for (k = 0; k < PHASE_WORDS; k++) begin
        pending_words.push_back(random_word());
      end
      wait_idle();
    end

    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
